// ===== hw/rtl/codk_pkg.sv =====
// ----------------------------------------------------------------------------
// codk_pkg
// Shared types, constants and microcode for the clock offset/drift filter.
// ----------------------------------------------------------------------------
package codk_pkg;

  localparam int FRAC_BITS = 24;
  localparam int W = 64;

  localparam logic [W-1:0] SIGN_VAL    = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_VAL     = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] Q_ONE       = W'(64'd1) << FRAC_BITS;
  localparam logic [W-1:0] Q_QUARTER   = W'(64'd1) << (FRAC_BITS - 2);
  localparam logic [W-1:0] Q_OO_INIT   = W'(64'd1000000000) << FRAC_BITS;
  localparam logic [W-1:0] Q_DD_INIT   = W'(64'd1000) << FRAC_BITS;
  localparam logic [62:0]  ONR_RESET   = 63'd16777216;
  localparam logic [62:0]  DNR_RESET   = 63'd16777;

  typedef enum logic [1:0] {
    MODE_PREDICT = 2'd0,
    MODE_UPDATE  = 2'd1,
    MODE_LOAD    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    CFG_OFFSET_NOISE = 1'b0,
    CFG_DRIFT_NOISE  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SKIPNP, OP_LOCK, OP_END
  } op_t;

  typedef enum logic [3:0] {
    R_OE, R_DE, R_P00, R_P01, R_P10, R_P11, R_NO, R_ND,
    R_IN, R_MV, R_T0, R_T1, R_T2, R_T3, R_T4, R_ONE
  } reg_sel_t;

  typedef struct packed {
    op_t      op;
    reg_sel_t a;
    reg_sel_t b;
    reg_sel_t d;
  } uop_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_EXEC, S_WAIT, S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    A_IDLE, A_MUL, A_DIV
  } alu_state_t;

  localparam logic [5:0] PC_PREDICT = 6'd0;
  localparam logic [5:0] PC_UPDATE  = 6'd17;

  function automatic uop_t ucode(input logic [5:0] pc);
    uop_t u;
    u = '{OP_END, R_OE, R_OE, R_OE};
    case (pc)
      // predict
      6'd0:  u = '{OP_SKIPNP, R_IN,  R_IN,  R_IN};
      6'd1:  u = '{OP_MUL,    R_DE,  R_IN,  R_T0};
      6'd2:  u = '{OP_ADD,    R_OE,  R_T0,  R_OE};
      6'd3:  u = '{OP_ADD,    R_P01, R_P10, R_T0};
      6'd4:  u = '{OP_MUL,    R_IN,  R_T0,  R_T0};
      6'd5:  u = '{OP_ADD,    R_P00, R_T0,  R_T0};
      6'd6:  u = '{OP_MUL,    R_IN,  R_IN,  R_T1};
      6'd7:  u = '{OP_MUL,    R_T1,  R_P11, R_T1};
      6'd8:  u = '{OP_ADD,    R_T0,  R_T1,  R_T0};
      6'd9:  u = '{OP_MUL,    R_IN,  R_P11, R_T1};
      6'd10: u = '{OP_MUL,    R_NO,  R_IN,  R_T2};
      6'd11: u = '{OP_ADD,    R_T0,  R_T2,  R_P00};
      6'd12: u = '{OP_ADD,    R_P01, R_T1,  R_P01};
      6'd13: u = '{OP_ADD,    R_P10, R_T1,  R_P10};
      6'd14: u = '{OP_MUL,    R_ND,  R_IN,  R_T2};
      6'd15: u = '{OP_ADD,    R_P11, R_T2,  R_P11};
      6'd16: u = '{OP_END,    R_OE,  R_OE,  R_OE};
      // measurement update
      6'd17: u = '{OP_SUB,    R_IN,  R_OE,  R_T0};
      6'd18: u = '{OP_ADD,    R_P00, R_MV,  R_T1};
      6'd19: u = '{OP_SKIPNP, R_T1,  R_T1,  R_T1};
      6'd20: u = '{OP_DIV,    R_P00, R_T1,  R_T2};
      6'd21: u = '{OP_DIV,    R_P10, R_T1,  R_T3};
      6'd22: u = '{OP_MUL,    R_T2,  R_T0,  R_T4};
      6'd23: u = '{OP_ADD,    R_OE,  R_T4,  R_OE};
      6'd24: u = '{OP_MUL,    R_T3,  R_T0,  R_T4};
      6'd25: u = '{OP_ADD,    R_DE,  R_T4,  R_DE};
      6'd26: u = '{OP_SUB,    R_ONE, R_T2,  R_T2};
      6'd27: u = '{OP_MUL,    R_T3,  R_P00, R_T4};
      6'd28: u = '{OP_MUL,    R_T3,  R_P01, R_T0};
      6'd29: u = '{OP_MUL,    R_T2,  R_P00, R_P00};
      6'd30: u = '{OP_MUL,    R_T2,  R_P01, R_P01};
      6'd31: u = '{OP_SUB,    R_P10, R_T4,  R_P10};
      6'd32: u = '{OP_SUB,    R_P11, R_T0,  R_P11};
      6'd33: u = '{OP_LOCK,   R_OE,  R_OE,  R_OE};
      default: u = '{OP_END, R_OE, R_OE, R_OE};
    endcase
    return u;
  endfunction

  // magnitude to signed with clipping: {sat, value}
  function automatic logic [W:0] from_mag(input logic [W-1:0] m, input logic neg);
    logic [W:0] r;
    if (neg) begin
      if (m > SIGN_VAL) r = {1'b1, SIGN_VAL};
      else r = {1'b0, W'(-m)};
    end else begin
      if (m[W-1]) r = {1'b1, MAX_VAL};
      else r = {1'b0, m};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/codk_alu.sv =====
// ----------------------------------------------------------------------------
// codk_alu
// Shared saturating add/sub, Q-format multiply (four 32x32 partial products)
// and restoring divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module codk_alu
  import codk_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  op_t          op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] res,
  output logic         sat
);

  alu_state_t state, state_next;
  logic [6:0]   cnt;
  logic [127:0] acc;
  logic [W-1:0] ua, ub, rem, qlo, quo;
  logic         neg;

  logic [W-1:0] ma, mb, sum, dif;
  logic         add_ovf, sub_ovf;
  logic [31:0]  ha, hb;
  logic [W-1:0] pp;
  logic [6:0]   sh;
  logic [W:0]   trial;
  logic         ge;
  logic [W-1:0] dhi;
  logic [W:0]   fm_mul, fm_div, fm_dsat;
  logic         mul_ovf;

  always_comb begin
    ma = a[W-1] ? W'(-a) : a;
    mb = b[W-1] ? W'(-b) : b;
    sum = a + b;
    dif = a - b;
    add_ovf = (a[W-1] == b[W-1]) && (sum[W-1] != a[W-1]);
    sub_ovf = (a[W-1] != b[W-1]) && (dif[W-1] != a[W-1]);
    dhi = W'(ma >> (W - FRAC_BITS));
    fm_dsat = {1'b1, ((a[W-1] != b[W-1]) ? SIGN_VAL : MAX_VAL)};
    ha = cnt[0] ? ua[63:32] : ua[31:0];
    hb = cnt[1] ? ub[63:32] : ub[31:0];
    pp = ha * hb;
    // partial product weight: 32 bits per high half
    sh = {cnt[0] & cnt[1], cnt[0] ^ cnt[1], 5'd0};
    trial = {rem, qlo[W-1]};
    ge = trial >= {1'b0, ub};
    mul_ovf = |acc[127:W+FRAC_BITS];
    fm_mul = from_mag(acc[W+FRAC_BITS-1:FRAC_BITS], neg);
    fm_div = from_mag(quo, neg);
  end

  always_comb begin
    state_next = state;
    case (state)
      A_IDLE: begin
        if (start && op == OP_MUL) state_next = A_MUL;
        else if (start && op == OP_DIV && mb != '0 && dhi < mb) state_next = A_DIV;
      end
      A_MUL: if (cnt == 7'd4) state_next = A_IDLE;
      A_DIV: if (cnt == 7'd64) state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      case (state)
        A_IDLE: begin
          cnt <= '0;
          if (start) begin
            ua <= ma;
            ub <= mb;
            neg <= a[W-1] != b[W-1];
            acc <= 128'(1) << (FRAC_BITS - 1);
            rem <= dhi;
            qlo <= ma << FRAC_BITS;
            quo <= '0;
            case (op)
              OP_ADD: begin
                done <= 1'b1;
                sat <= add_ovf;
                res <= add_ovf ? (a[W-1] ? SIGN_VAL : MAX_VAL) : sum;
              end
              OP_SUB: begin
                done <= 1'b1;
                sat <= sub_ovf;
                res <= sub_ovf ? (a[W-1] ? SIGN_VAL : MAX_VAL) : dif;
              end
              OP_DIV: begin
                if (mb == '0 || dhi >= mb) begin
                  done <= 1'b1;
                  sat <= fm_dsat[W];
                  res <= fm_dsat[W-1:0];
                end
              end
              default: ;
            endcase
          end
        end
        A_MUL: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd4) begin
            done <= 1'b1;
            sat <= mul_ovf | fm_mul[W];
            res <= mul_ovf ? (neg ? SIGN_VAL : MAX_VAL) : fm_mul[W-1:0];
          end else begin
            acc <= acc + (128'(pp) << sh);
          end
        end
        A_DIV: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd64) begin
            done <= 1'b1;
            sat <= fm_div[W];
            res <= fm_div[W-1:0];
          end else begin
            rem <= ge ? W'(trial - {1'b0, ub}) : trial[W-1:0];
            quo <= {quo[W-2:0], ge};
            qlo <= qlo << 1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/clock_offset_drift_kalman.sv =====
// ----------------------------------------------------------------------------
// clock_offset_drift_kalman
// Two-state Kalman filter for clock offset and drift, signed Q40.24.
// ----------------------------------------------------------------------------
// One request at a time through a microcoded sequencer driving one shared
// arithmetic unit. Reset and unused modes skip the microcode. Predict runs
// 7 multiplies and 8 adds. A measurement update takes its time mostly from
// the two serial divisions. Predict with dt <= 0 and update with innovation
// variance <= 0 end early.
module clock_offset_drift_kalman
  import codk_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [62:0]  cfg_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   mode,
  input  logic [63:0]  value,
  input  logic [63:0]  meas_variance,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [63:0]  offset_estimate,
  output logic [63:0]  drift_estimate,
  output logic [63:0]  offset_variance,
  output logic         locked,
  output logic         saturated
);

  seq_state_t state, state_next;
  logic [5:0]   pc;
  logic [62:0]  onr, dnr;
  logic [W-1:0] oe, de, p00, p01, p10, p11, vin, mv, t0, t1, t2, t3, t4;
  logic [W-1:0] op_a, op_b;
  logic         lock_flag, sat_acc;
  uop_t         u;
  logic         alu_start, alu_done, alu_sat;
  logic [W-1:0] alu_res, src_a, src_b;
  logic         nonpos;

  function automatic logic [W-1:0] rd(input reg_sel_t s, input logic [W-1:0] o_e,
      input logic [W-1:0] d_e, input logic [W-1:0] q00, input logic [W-1:0] q01,
      input logic [W-1:0] q10, input logic [W-1:0] q11, input logic [W-1:0] x_in,
      input logic [W-1:0] x_mv, input logic [W-1:0] x0, input logic [W-1:0] x1,
      input logic [W-1:0] x2, input logic [W-1:0] x3, input logic [W-1:0] x4,
      input logic [62:0] n_o, input logic [62:0] n_d);
    logic [W-1:0] r;
    case (s)
      R_OE:  r = o_e;
      R_DE:  r = d_e;
      R_P00: r = q00;
      R_P01: r = q01;
      R_P10: r = q10;
      R_P11: r = q11;
      R_NO:  r = {1'b0, n_o};
      R_ND:  r = {1'b0, n_d};
      R_IN:  r = x_in;
      R_MV:  r = x_mv;
      R_T0:  r = x0;
      R_T1:  r = x1;
      R_T2:  r = x2;
      R_T3:  r = x3;
      R_T4:  r = x4;
      R_ONE: r = Q_ONE;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign u = ucode(pc);
  assign src_a = rd(u.a, oe, de, p00, p01, p10, p11, vin, mv, t0, t1, t2, t3, t4, onr, dnr);
  assign src_b = rd(u.b, oe, de, p00, p01, p10, p11, vin, mv, t0, t1, t2, t3, t4, onr, dnr);
  assign nonpos = src_a[W-1] || (src_a == '0);
  assign in_ready = (state == S_IDLE);
  assign alu_start = (state == S_EXEC);

  codk_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .op    (u.op),
    .a     (op_a),
    .b     (op_b),
    .done  (alu_done),
    .res   (alu_res),
    .sat   (alu_sat)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (mode_t'(mode))
            MODE_PREDICT, MODE_UPDATE: state_next = S_FETCH;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_FETCH: begin
        case (u.op)
          OP_SKIPNP: if (nonpos) state_next = S_DONE;
          OP_LOCK, OP_END: state_next = S_DONE;
          default: state_next = S_EXEC;
        endcase
      end
      S_EXEC: state_next = S_WAIT;
      S_WAIT: if (alu_done) state_next = S_FETCH;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      onr <= ONR_RESET;
      dnr <= DNR_RESET;
      oe <= '0;
      de <= '0;
      p00 <= Q_OO_INIT;
      p01 <= '0;
      p10 <= '0;
      p11 <= Q_DD_INIT;
      lock_flag <= 1'b0;
      sat_acc <= 1'b0;
      out_valid <= 1'b0;
      pc <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_OFFSET_NOISE: onr <= cfg_data;
          CFG_DRIFT_NOISE:  dnr <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sat_acc <= 1'b0;
            vin <= value;
            mv <= (meas_variance[W-1] || meas_variance < Q_QUARTER) ? Q_QUARTER
                                                                     : meas_variance;
            pc <= (mode_t'(mode) == MODE_UPDATE) ? PC_UPDATE : PC_PREDICT;
            if (mode_t'(mode) == MODE_LOAD) begin
              oe <= value;
              de <= '0;
              p00 <= Q_OO_INIT;
              p01 <= '0;
              p10 <= '0;
              p11 <= Q_DD_INIT;
              lock_flag <= 1'b0;
            end
          end
        end
        S_FETCH: begin
          op_a <= src_a;
          op_b <= src_b;
          if (u.op == OP_SKIPNP) pc <= pc + 6'd1;
          if (u.op == OP_LOCK) lock_flag <= 1'b1;
        end
        S_WAIT: begin
          if (alu_done) begin
            sat_acc <= sat_acc | alu_sat;
            pc <= pc + 6'd1;
            case (u.d)
              R_OE:  oe  <= alu_res;
              R_DE:  de  <= alu_res;
              R_P00: p00 <= alu_res;
              R_P01: p01 <= alu_res;
              R_P10: p10 <= alu_res;
              R_P11: p11 <= alu_res;
              R_T0:  t0  <= alu_res;
              R_T1:  t1  <= alu_res;
              R_T2:  t2  <= alu_res;
              R_T3:  t3  <= alu_res;
              R_T4:  t4  <= alu_res;
              default: ;
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            offset_estimate <= oe;
            drift_estimate <= de;
            offset_variance <= p00;
            locked <= lock_flag;
            saturated <= sat_acc;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the clock offset/drift filter against a fixed-point predictor of its
// own. Directed requests cover each mode, the extremes of the fields and every
// skip, floor and clipping case; random predict/update sequences with random
// noise registers follow, with random stalls on both handshakes.
// ----------------------------------------------------------------------------
module testbench;
  import codk_pkg::*;

  typedef struct packed {
    logic [63:0] oe;
    logic [63:0] de;
    logic [63:0] ov;
    logic        lk;
    logic        sat;
  } estimate_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = CFG_OFFSET_NOISE;
  logic [62:0]  cfg_data = '0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic [1:0]   mode = MODE_PREDICT;
  logic [63:0]  value = '0;
  logic [63:0]  meas_variance = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [63:0]  offset_estimate;
  logic [63:0]  drift_estimate;
  logic [63:0]  offset_variance;
  logic         locked;
  logic         saturated;

  clock_offset_drift_kalman dut (.*);

  always #10 clk = ~clk;

  // filter state mirror
  logic [63:0] m_onr, m_dnr, m_oe, m_de, m_p00, m_p01, m_p10, m_p11;
  logic        m_lock, m_sat;
  estimate_t   pending_estimates[$];
  int          errors = 0;
  int          n_results = 0;
  int          n_requests = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  bit          done_flag = 1'b0;

  function automatic logic neg64(logic [63:0] x);
    return x[63];
  endfunction

  function automatic logic [63:0] mag64(logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic logic [63:0] clip(logic [63:0] m, logic ng);
    logic [63:0] lim;
    lim = ng ? SIGN_VAL : MAX_VAL;
    if (m > lim) begin
      m = lim;
      m_sat = 1'b1;
    end
    return ng ? -m : m;
  endfunction

  function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      m_sat = 1'b1;
      return a[63] ? SIGN_VAL : MAX_VAL;
    end
    return r;
  endfunction

  function automatic logic [63:0] ssub(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) begin
      m_sat = 1'b1;
      return a[63] ? SIGN_VAL : MAX_VAL;
    end
    return r;
  endfunction

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    logic [63:0]  m;
    logic         ng;
    ng = neg64(a) != neg64(b);
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    p = p + (128'd1 << (FRAC_BITS - 1));
    if ((p >> (64 + FRAC_BITS)) != 0) begin
      m_sat = 1'b1;
      m = ng ? SIGN_VAL : SIGN_VAL + 64'd1;
    end else begin
      m = p[FRAC_BITS +: 64];
    end
    return clip(m, ng);
  endfunction

  function automatic logic [63:0] qdiv(logic [63:0] a, logic [63:0] b);
    logic [127:0] n;
    logic [127:0] q;
    logic         ng;
    ng = neg64(a) != neg64(b);
    n = {64'd0, mag64(a)} << FRAC_BITS;
    if (mag64(b) == 0 || (n >> 64) >= {64'd0, mag64(b)}) begin
      m_sat = 1'b1;
      return ng ? SIGN_VAL : MAX_VAL;
    end
    q = n / {64'd0, mag64(b)};
    return clip(q[63:0], ng);
  endfunction

  task automatic load_state(logic [63:0] start);
    m_oe = start;
    m_de = '0;
    m_p00 = Q_OO_INIT;
    m_p01 = '0;
    m_p10 = '0;
    m_p11 = Q_DD_INIT;
    m_lock = 1'b0;
  endtask

  task automatic advance_filter(logic [1:0] md, logic [63:0] v, logic [63:0] mv);
    logic [63:0] t, dp, r, y, s, k0, k1, omk, p00, p01, p10, p11;
    p00 = m_p00; p01 = m_p01; p10 = m_p10; p11 = m_p11;
    m_sat = 1'b0;
    if (md == MODE_PREDICT) begin
      if (!v[63] && v != 0) begin
        m_oe = sadd(m_oe, qmul(m_de, v));
        t = sadd(p00, qmul(v, sadd(p01, p10)));
        t = sadd(t, qmul(qmul(v, v), p11));
        dp = qmul(v, p11);
        m_p00 = sadd(t, qmul(m_onr, v));
        m_p01 = sadd(p01, dp);
        m_p10 = sadd(p10, dp);
        m_p11 = sadd(p11, qmul(m_dnr, v));
      end
    end else if (md == MODE_UPDATE) begin
      r = (mv[63] || mv < Q_QUARTER) ? Q_QUARTER : mv;
      y = ssub(v, m_oe);
      s = sadd(p00, r);
      if (!s[63] && s != 0) begin
        k0 = qdiv(p00, s);
        k1 = qdiv(p10, s);
        m_oe = sadd(m_oe, qmul(k0, y));
        m_de = sadd(m_de, qmul(k1, y));
        omk = ssub(Q_ONE, k0);
        m_p00 = qmul(omk, p00);
        m_p01 = qmul(omk, p01);
        m_p10 = ssub(p10, qmul(k1, p00));
        m_p11 = ssub(p11, qmul(k1, p01));
        m_lock = 1'b1;
      end
    end else if (md == MODE_LOAD) begin
      load_state(v);
    end
    pending_estimates.push_back('{m_oe, m_de, m_p00, m_lock, m_sat});
  endtask

  function automatic bit idle_roll();
    return !quiet && $urandom_range(99) < 12;
  endfunction

  // valid stays up after acceptance only when the next request follows at once
  task automatic send_request(logic [1:0] md, logic [63:0] v, logic [63:0] mv);
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    advance_filter(md, v, mv);
    in_valid <= 1'b1;
    mode <= md;
    value <= v;
    meas_variance <= mv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_requests++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [62:0] d);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OFFSET_NOISE) m_onr = {1'b0, d};
    else m_dnr = {1'b0, d};
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // small Q value below 2^(k+1) in raw magnitude
  function automatic logic [63:0] rand_q(int k, bit sgn);
    logic [63:0] x;
    x = rand64() >> (63 - k);
    return (sgn && $urandom_range(1)) ? -x : x;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_roll();
      if (out_valid && out_ready) begin
        if (pending_estimates.size() == 0) begin
          $display("%0t: unexpected result oe=%h", $time, offset_estimate);
          errors++;
        end else begin
          estimate_t e;
          e = pending_estimates.pop_front();
          n_results++;
          if (e.oe !== offset_estimate || e.de !== drift_estimate ||
              e.ov !== offset_variance || e.lk !== locked || e.sat !== saturated) begin
            errors++;
            $display("%0t: mismatch expected oe=%h de=%h ov=%h lk=%b sat=%b", $time,
                     e.oe, e.de, e.ov, e.lk, e.sat);
            $display("%0t:          actual   oe=%h de=%h ov=%h lk=%b sat=%b", $time,
                     offset_estimate, drift_estimate, offset_variance, locked, saturated);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == 2000000 && !done_flag) begin
      $display("Timeout with %0d results outstanding", pending_estimates.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_modes();
    send_request(MODE_PREDICT, Q_ONE, '0);
    send_request(MODE_UPDATE, 64'd5 << FRAC_BITS, Q_ONE);
    send_request(MODE_PREDICT, Q_ONE >> 1, '0);
    send_request(MODE_UPDATE, -(64'd3 << FRAC_BITS), 64'd1 << 20);
    send_request(MODE_NONE, rand64(), rand64());
    send_request(MODE_LOAD, 64'd100 << FRAC_BITS, rand64());
    send_request(MODE_UPDATE, 64'd101 << FRAC_BITS, 64'd2 << FRAC_BITS);
  endtask

  task automatic test_edges();
    send_request(MODE_PREDICT, '0, '0);
    send_request(MODE_PREDICT, SIGN_VAL, MAX_VAL);
    send_request(MODE_PREDICT, -Q_ONE, '0);
    send_request(MODE_UPDATE, MAX_VAL, SIGN_VAL);
    send_request(MODE_UPDATE, SIGN_VAL, MAX_VAL);
    send_request(MODE_PREDICT, MAX_VAL, '0);
    send_request(MODE_UPDATE, '0, '0);
    send_request(MODE_LOAD, SIGN_VAL, '0);
    send_request(MODE_UPDATE, MAX_VAL, Q_QUARTER - 1);
    send_request(MODE_LOAD, MAX_VAL, '0);
    send_request(MODE_PREDICT, 64'd1, '0);
    send_request(MODE_UPDATE, 64'd0, '1);
    // innovation variance saturates after clipping cov
    send_request(MODE_LOAD, '0, '0);
    send_request(MODE_PREDICT, 64'd1 << 50, '0);
    send_request(MODE_UPDATE, Q_ONE, MAX_VAL);
    send_request(MODE_NONE, '0, '0);
  endtask

  task automatic test_registers();
    write_reg(CFG_OFFSET_NOISE, '1);
    write_reg(CFG_DRIFT_NOISE, '1);
    send_request(MODE_LOAD, '0, '0);
    send_request(MODE_PREDICT, Q_ONE, '0);
    write_reg(CFG_OFFSET_NOISE, '0);
    write_reg(CFG_DRIFT_NOISE, '0);
    send_request(MODE_LOAD, Q_ONE, '0);
    send_request(MODE_PREDICT, Q_ONE << 3, '0);
    write_reg(CFG_OFFSET_NOISE, ONR_RESET);
    write_reg(CFG_DRIFT_NOISE, DNR_RESET);
  endtask

  task automatic random_phase(int n, bit wide);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (wide && r < 10)
        send_request(2'($urandom_range(3)), rand64(), rand64());
      else if (r < 3)
        send_request(MODE_LOAD, rand_q(34, 1), rand64());
      else if (r < 5)
        send_request(MODE_NONE, rand64(), rand64());
      else if (r < 50)
        send_request(MODE_PREDICT, ($urandom_range(9) == 0) ? rand_q(30, 1) : rand_q(26, 0),
                     rand64());
      else
        send_request(MODE_UPDATE, m_oe + rand_q(30, 1),
                     ($urandom_range(7) == 0) ? rand64() : rand_q(28, 1));
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_OFFSET_NOISE, 63'({$urandom, $urandom} >> (1 + $urandom_range(62))));
      write_reg(CFG_DRIFT_NOISE, 63'({$urandom, $urandom} >> (1 + $urandom_range(62))));
      send_request(MODE_LOAD, rand_q(20, 1), '0);
      quiet = (ph == 2);
      random_phase(215, ph == 4);
      quiet = 1'b0;
      drain();
    end
  endtask

  initial begin
    m_onr = {1'b0, ONR_RESET};
    m_dnr = {1'b0, DNR_RESET};
    load_state('0);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_modes();
    test_edges();
    test_registers();
    test_random();
    drain();
    repeat (300) @(posedge clk);
    done_flag = 1'b1;
    $display("Covered %0d requests in all modes, %0d results checked,", n_requests, n_results);
    $display("including skips, variance floor, clipping and register extremes.");
    if (errors == 0 && pending_estimates.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
